>>> rtl/btsd_pkg.sv
// Package for the timed server dispatcher: field widths, result kinds,
// register map and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package btsd_pkg;

  // Fixed field widths of the request and result items.
  localparam int TIME_W    = 30;
  localparam int BUSY_W    = 31;
  localparam int COUNT_W   = 32;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 5;
  localparam int CFG_W     = 6;

  // Built server limit used as the default of the top-level parameter.
  localparam int MAX_SERVERS_DEF = 32;

  // Configuration port layout.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_NUM_SERVERS = 1'b0;
  localparam logic [CFG_W-1:0] NUM_SERVERS_RST = 6'd32;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic do_cmp;
    logic do_pick;
    logic max_step;
    logic rep_step;
  } btsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_req;
    logic out_free;
    logic walk_last;
    logic rep_at_last;
  } btsd_stat_t;

endpackage

>>> rtl/btsd_if.sv
// Handshake channel interfaces for requests and results.
// Depends on btsd_pkg for the field widths.
`timescale 1ns / 1ps

interface btsd_req_if import btsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] service_time;
  logic              final_request;

  modport source (output valid, arrival_time, service_time, final_request, input ready);
  modport sink   (input valid, arrival_time, service_time, final_request, output ready);
endinterface

interface btsd_res_if import btsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [INDEX_W-1:0] server_index;
  logic               run_end;

  modport source (output valid, result_kind, server_index, run_end, input ready);
  modport sink   (input valid, result_kind, server_index, run_end, output ready);
endinterface

>>> rtl/busy_timed_server_dispatcher_unit.sv
// Top level of the timed server dispatcher: configuration register, controller
// and datapath. Depends on btsd_pkg, btsd_if, btsd_ctrl and btsd_datapath.
//
// Usage: requests come in on the req channel (arrival_time, service_time,
// final_request) and results leave on the res channel (result_kind,
// server_index, run_end), both valid/ready; an item moves when both are high.
// The num_servers register (byte address 0, APB port, pready always high)
// sets how many servers take part; write it only while the block is idle.
// Each request gives one result, assigned or dropped: the edge that accepts
// it captures the request, the compare state stores the parallel free test
// of all busy times and the pick state runs the rotating pick that loads the
// result register.
// A final request adds a maximum pass and a report pass over the served
// counts of the active servers, one server per cycle (the report pass only
// while the result register is free), then clears all server state. The
// next request can be accepted while a result still waits in the output
// register. A stalled receiver holds the pick or report step until the
// result register frees.
// Reset clears every server to free with a zero count and sets num_servers
// to 32.
`timescale 1ns / 1ps

module busy_timed_server_dispatcher_unit import btsd_pkg::*; #(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  btsd_req_if.sink              req,
  btsd_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] num_servers;
  btsd_cmd_t        cmd;
  btsd_stat_t       stat;

  // Configuration register write and read back.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUM_SERVERS) ? APB_DATA_W'(num_servers) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= NUM_SERVERS_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NUM_SERVERS)) begin
      num_servers <= pwdata[CFG_W-1:0];
    end
  end

  btsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  btsd_datapath #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .num_servers   (num_servers),
    .arrival_time  (req.arrival_time),
    .service_time  (req.service_time),
    .final_request (req.final_request),
    .cmd           (cmd),
    .stat          (stat),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .result_kind   (res.result_kind),
    .server_index  (res.server_index),
    .run_end       (res.run_end)
  );

endmodule

>>> rtl/btsd_ctrl.sv
// Controller state machine of the dispatcher: sequences accept, compare,
// pick, the maximum pass and the report pass. Depends on btsd_pkg.
`timescale 1ns / 1ps

module btsd_ctrl import btsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  btsd_stat_t stat,
  output btsd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_MAX  = 3'd3;
  localparam logic [2:0] S_REP  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CMP;
        end
      end
      S_CMP: begin
        cmd.do_cmp = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        if (stat.out_free) begin
          cmd.do_pick = 1'b1;
          state_next  = stat.final_req ? S_MAX : S_IDLE;
        end
      end
      S_MAX: begin
        cmd.max_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_REP;
        end
      end
      S_REP: begin
        if (stat.out_free) begin
          cmd.rep_step = 1'b1;
          if (stat.rep_at_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A report pass always ends on the last matching server.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REP) && cmd.rep_step && stat.rep_at_last |=> state == S_IDLE)
    else $error("report pass did not return to idle");

  // At most one command is issued per cycle.
  assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // A request is taken only from idle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |-> (state == S_IDLE) && req_valid)
    else $error("request loaded outside idle");

endmodule

>>> rtl/btsd_datapath.sv
// Datapath of the dispatcher: per-server busy times and served counts,
// parallel free test, rotating pick, max/report walk and result register.
// Depends on btsd_pkg.
`timescale 1ns / 1ps

module btsd_datapath import btsd_pkg::*; #(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CFG_W-1:0]   num_servers,
  input  logic [TIME_W-1:0]  arrival_time,
  input  logic [TIME_W-1:0]  service_time,
  input  logic               final_request,
  input  btsd_cmd_t          cmd,
  output btsd_stat_t         stat,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [KIND_W-1:0]  result_kind,
  output logic [INDEX_W-1:0] server_index,
  output logic               run_end
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  // Per-server state.
  logic [BUSY_W-1:0]  busy_until   [MAX_SERVERS];
  logic [COUNT_W-1:0] served_count [MAX_SERVERS];
  logic [IDX_W-1:0]   preferred_start;
  logic [COUNT_W-1:0] highest_count;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   walk_idx;

  // Captured request and compare results.
  logic [TIME_W-1:0]      arrival_q;
  logic [TIME_W-1:0]      service_q;
  logic                   final_q;
  logic [MAX_SERVERS-1:0] free_vec;
  logic [BUSY_W-1:0]      finish_q;
  logic [IDX_W-1:0]       start_q;

  logic [CNT_W-1:0]       n_active;
  logic [IDX_W-1:0]       start_c;
  logic [MAX_SERVERS-1:0] hi_vec;
  logic [MAX_SERVERS-1:0] pick_vec;
  logic [IDX_W-1:0]       pick_idx;
  logic                   found;
  logic [CNT_W-1:0]       start_inc;
  logic [COUNT_W-1:0]     walk_count;
  logic                   rep_match;
  logic                   clear_all;
  logic                   load_out;

  // Effective server count, clamped to 1..MAX_SERVERS.
  always_comb begin
    if (num_servers == '0) begin
      n_active = CNT_W'(1);
    end else if (num_servers > CFG_W'(MAX_SERVERS)) begin
      n_active = CNT_W'(MAX_SERVERS);
    end else begin
      n_active = CNT_W'(num_servers);
    end
  end

  // A stale preferred start beyond the count falls back to server zero.
  assign start_c = (CNT_W'(preferred_start) < n_active) ? preferred_start : '0;

  // Rotating priority pick: first free server at or above start, else lowest free.
  always_comb begin
    for (int k = 0; k < MAX_SERVERS; k++) begin
      hi_vec[k] = free_vec[k] && (CNT_W'(k) >= CNT_W'(start_q));
    end
    pick_vec = (|hi_vec) ? hi_vec : free_vec;
    pick_idx = '0;
    for (int k = MAX_SERVERS - 1; k >= 0; k--) begin
      if (pick_vec[k]) begin
        pick_idx = IDX_W'(k);
      end
    end
  end

  assign found     = |free_vec;
  assign start_inc = CNT_W'(start_q) + CNT_W'(1);

  // Walk read of one served count for the max and report passes.
  assign walk_count = served_count[walk_idx];
  assign rep_match  = (walk_count == highest_count);
  assign clear_all  = cmd.rep_step && (walk_idx == last_idx);
  assign load_out   = cmd.do_pick || (cmd.rep_step && rep_match);

  assign stat.final_req   = final_q;
  assign stat.out_free    = !res_valid || res_ready;
  assign stat.walk_last   = (CNT_W'(walk_idx) == n_active - CNT_W'(1));
  assign stat.rep_at_last = (walk_idx == last_idx);

  // Request capture and the parallel free test.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      arrival_q <= arrival_time;
      service_q <= service_time;
      final_q   <= final_request;
    end
    if (cmd.do_cmp) begin
      for (int k = 0; k < MAX_SERVERS; k++) begin
        free_vec[k] <= (busy_until[k] <= {1'b0, arrival_q}) && (CNT_W'(k) < n_active);
      end
      finish_q <= {1'b0, arrival_q} + {1'b0, service_q};
      start_q  <= start_c;
    end
  end

  // Server state: updated on a pick and in the max pass, cleared at reset and after a report.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      for (int k = 0; k < MAX_SERVERS; k++) begin
        busy_until[k]   <= '0;
        served_count[k] <= '0;
      end
      preferred_start <= '0;
      highest_count   <= '0;
    end else if (cmd.do_pick) begin
      if (found) begin
        busy_until[pick_idx] <= finish_q;
        if (served_count[pick_idx] != COUNT_SAT) begin
          served_count[pick_idx] <= served_count[pick_idx] + COUNT_W'(1);
        end
      end
      preferred_start <= (start_inc >= n_active) ? '0 : IDX_W'(start_inc);
      highest_count   <= '0;
    end else if (cmd.max_step) begin
      if (walk_count > highest_count) begin
        highest_count <= walk_count;
      end
    end
  end

  // Walk index and the last server that holds the maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx <= '0;
      last_idx <= '0;
    end else if (cmd.do_pick) begin
      walk_idx <= '0;
      last_idx <= '0;
    end else if (cmd.max_step) begin
      if (walk_count >= highest_count) begin
        last_idx <= walk_idx;
      end
      walk_idx <= stat.walk_last ? '0 : walk_idx + IDX_W'(1);
    end else if (cmd.rep_step) begin
      walk_idx <= walk_idx + IDX_W'(1);
    end
  end

  // Result register: holds one item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_pick) begin
      result_kind  <= found ? KIND_ASSIGN : KIND_DROP;
      server_index <= found ? INDEX_W'(pick_idx) : '0;
      run_end      <= !final_q;
    end else if (cmd.rep_step && rep_match) begin
      result_kind  <= KIND_REPORT;
      server_index <= INDEX_W'(walk_idx);
      run_end      <= clear_all;
    end
  end

  // The picked server is always an active one.
  assert property (@(posedge clk) disable iff (rst)
    cmd.do_pick && found |-> CNT_W'(pick_idx) < n_active)
    else $error("picked server outside the active range");

  // The last report entry is always a server holding the maximum.
  assert property (@(posedge clk) disable iff (rst)
    cmd.rep_step && stat.rep_at_last |-> rep_match)
    else $error("last report entry does not hold the maximum");

  // The result register is never overwritten while an item waits.
  assert property (@(posedge clk) disable iff (rst)
    load_out |-> !res_valid || res_ready)
    else $error("result overwritten before it was taken");

  // The max pass never reads past the active servers.
  assert property (@(posedge clk) disable iff (rst)
    cmd.max_step |-> CNT_W'(walk_idx) < n_active)
    else $error("max pass beyond the active servers");

endmodule
